[rtl/core/ntc_pkg.sv]
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared constants, the resistance/temperature table and the item record
// for the NTC thermistor temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

	// Field and register widths.
	localparam int ADC_W   = 12;
	localparam int PD_W    = 19;
	localparam int COEFF_W = 48;
	localparam int TEMP_W  = 17;
	localparam int CIDX_W  = 2;

	// Defaults for the top-level parameters.
	localparam int TABLE_POINTS_DEF   = 14;
	localparam int ADC_FULL_SCALE_DEF = 4095;

	// Table storage.
	localparam int TABLE_CAP = 64;
	localparam int SEG_W     = 6;
	localparam int TI_W      = 16;
	localparam int DR_W      = 20;
	localparam int DT_W      = 16;
	localparam int TDR_W     = 48;
	localparam int NUM_W     = 48;
	localparam int DEN_W     = 40;

	// Register indexes on the configuration channel.
	localparam logic [CIDX_W-1:0] CFG_COEFF_A   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_COEFF_B   = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_COEFF_C   = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_PULLDOWN  = 2'd3;

	// Register reset values.
	localparam logic signed [COEFF_W-1:0] COEFF_A_RST = 48'sd314160000000;
	localparam logic signed [COEFF_W-1:0] COEFF_B_RST = 48'sd65900000000;
	localparam logic signed [COEFF_W-1:0] COEFF_C_RST = 48'sd25000000;
	localparam logic [PD_W-1:0]           PD_RST      = 19'd10000;

	// Arithmetic constants.
	localparam logic [31:0]        LN2_Q32       = 32'd2977044472;
	localparam logic [59:0]        SH_NUMER      = 60'hA00_0000_0000_0000;
	localparam logic signed [60:0] KELVIN_X10_M5 = 61'sd699259;
	localparam logic signed [60:0] SH_HALF_SPAN  = 61'sd655360;
	localparam logic [31:0]        RECIP10       = 32'hCCCC_CCCD;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 17'sd65535;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -17'sd65536;

	// Resistance points in ohms and temperatures in 1/100 degC.
	typedef logic signed [31:0] tbl_arr_t [TABLE_CAP];

	localparam tbl_arr_t TBL_RES = '{
		0: 32'sd43273, 1: 32'sd45349, 2: 32'sd47538, 3: 32'sd49847,
		4: 32'sd52306, 5: 32'sd54878, 6: 32'sd57594, 7: 32'sd60461,
		8: 32'sd63491, 9: 32'sd66692, 10: 32'sd70076, 11: 32'sd73654,
		12: 32'sd77438, 13: 32'sd81479, default: 32'sd0
	};

	localparam tbl_arr_t TBL_TEMP = '{
		0: 32'sd4389, 1: 32'sd4278, 2: 32'sd4167, 3: 32'sd4056,
		4: 32'sd3944, 5: 32'sd3833, 6: 32'sd3722, 7: 32'sd3611,
		8: 32'sd3500, 9: 32'sd3389, 10: 32'sd3278, 11: 32'sd3167,
		12: 32'sd3056, 13: 32'sd2944, default: 32'sd0
	};

	typedef logic signed [TDR_W-1:0] tdr_arr_t [TABLE_CAP];

	// Per-segment resistance step.
	function automatic tbl_arr_t build_dr();
		tbl_arr_t a;
		for (int i = 0; i < TABLE_CAP; i++) begin
			a[i] = (i + 1 < TABLE_CAP) ? TBL_RES[i+1] - TBL_RES[i] : 32'sd0;
		end
		return a;
	endfunction

	// Per-segment temperature step (falling).
	function automatic tbl_arr_t build_dt();
		tbl_arr_t a;
		for (int i = 0; i < TABLE_CAP; i++) begin
			a[i] = (i + 1 < TABLE_CAP) ? TBL_TEMP[i] - TBL_TEMP[i+1] : 32'sd0;
		end
		return a;
	endfunction

	// Per-segment product of start temperature and resistance step.
	function automatic tdr_arr_t build_tdr();
		tdr_arr_t a;
		tbl_arr_t dr;
		dr = build_dr();
		for (int i = 0; i < TABLE_CAP; i++) begin
			a[i] = TDR_W'(TBL_TEMP[i]) * TDR_W'(dr[i]);
		end
		return a;
	endfunction

	localparam tbl_arr_t TBL_DR  = build_dr();
	localparam tbl_arr_t TBL_DT  = build_dt();
	localparam tdr_arr_t TBL_TDR = build_tdr();

	// What the table stages hand on for one item.
	typedef struct packed {
		logic                    ok;
		logic                    tbl;
		logic                    sat_max;
		logic signed [NUM_W-1:0] tnum;
		logic [DEN_W-1:0]        tden;
	} ntc_item_t;

endpackage

`default_nettype wire

[rtl/core/ntc_adc_to_temperature_core.sv]
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_core
// NTC divider sample to temperature in 1/256 degC, table interpolation near
// the warm end and Steinhart-Hart elsewhere.
// ----------------------------------------------------------------------------
// The block takes one sample on every cycle in which s_tvalid and s_tready
// are high and delivers one result per sample, in order. The pipeline
// depth is set by the two bit-per-stage dividers (the resistance division
// and the final reciprocal or interpolation division) and the 24 squaring
// stages of the logarithm. All stages advance together while the output
// register is empty or being taken, so a stall on m_tready holds the whole
// pipe and s_tready follows it. Configuration writes are always accepted
// and should only be issued while no sample is in flight.
`default_nettype none

module ntc_adc_to_temperature_core import ntc_pkg::*; #(
	parameter int TABLE_POINTS   = TABLE_POINTS_DEF,
	parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Sample input.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,   // [11:0] adc_sample
	// Result output.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,   // [16:0] temperature
	output logic [1:0]          m_tuser,   // [0] valid_res, [1] from_table
	// Register writes.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [COEFF_W-1:0]  cfg_data
);

	localparam int FS_W = $clog2(ADC_FULL_SCALE + 1);
	localparam int RW   = FS_W + PD_W;
	localparam int EW   = $clog2(RW);
	localparam int LW   = EW + 17;
	localparam int L2W  = 2 * LW - 16;
	localparam int L3W  = 3 * LW - 32;
	localparam int H    = (L3W + 1) / 2;
	localparam int BLW  = COEFF_W + LW + 1;
	localparam int CLW  = COEFF_W + L3W + 1;
	localparam int DDW  = CLW - 16 + 2;
	localparam int QNW  = 60;
	localparam int QDW  = DDW - 1;
	localparam int ITW  = $bits(ntc_item_t);

	logic adv;

	// Configuration registers.
	logic signed [COEFF_W-1:0] coeff_a_q, coeff_b_q, coeff_c_q;
	logic [PD_W-1:0]           pd_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_a_q <= COEFF_A_RST;
			coeff_b_q <= COEFF_B_RST;
			coeff_c_q <= COEFF_C_RST;
			pd_q      <= PD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COEFF_A:  coeff_a_q <= cfg_data;
				CFG_COEFF_B:  coeff_b_q <= cfg_data;
				CFG_COEFF_C:  coeff_c_q <= cfg_data;
				CFG_PULLDOWN: pd_q      <= cfg_data[PD_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipe moves when the output register can take a result.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Resistance division: full scale times pull-down over the sample.
	logic [ADC_W-1:0] adc_c;
	logic [RW-1:0]    rdvd_c;
	logic             rd_vld, rd_zero;
	logic [RW-1:0]    rd_quo;
	logic [ADC_W-1:0] rd_rem;

	assign adc_c  = s_tdata[ADC_W-1:0];
	assign rdvd_c = RW'(ADC_FULL_SCALE) * RW'(pd_q);

	ntc_div #(.NW(RW), .DW(ADC_W), .TW(1)) u_rdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (s_tvalid && s_tready),
		.tag_i  (adc_c == '0),
		.dvd_i  (rdvd_c),
		.dvs_i  (adc_c),
		.vld_o  (rd_vld),
		.tag_o  (rd_zero),
		.quo_o  (rd_quo),
		.rem_o  (rd_rem)
	);

	// Segment search and interpolation operands.
	logic          tb_vld;
	ntc_item_t     tb_item;
	logic [RW-1:0] tb_r;

	ntc_tbl #(.RW(RW), .POINTS(TABLE_POINTS)) u_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (rd_vld),
		.ok_i   (!rd_zero && (rd_rem == rd_rem)),
		.rq_i   (rd_quo),
		.pd     (pd_q),
		.vld_o  (tb_vld),
		.item_o (tb_item),
		.r_o    (tb_r)
	);

	// Logarithm of the resistance.
	logic          ln_vld;
	logic [ITW-1:0] ln_tag;
	logic [LW-1:0] ln_l;

	ntc_ln #(.RW(RW), .TW(ITW), .EW(EW), .LW(LW)) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (tb_vld),
		.tag_i  (tb_item),
		.r_i    (tb_r),
		.vld_o  (ln_vld),
		.tag_o  (ln_tag),
		.l_o    (ln_l)
	);

	// Steinhart-Hart denominator, one multiply level per stage.
	logic      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ntc_item_t it_s1, it_s2, it_s3, it_s4, it_s5;
	logic [LW-1:0]  l_s1, l_s2;
	logic [L2W-1:0] l2_s1;
	logic [L3W-1:0] l3_s2;
	logic [2*LW-1:0]     sq_c;
	logic [L2W+LW-1:0]   cube_c;
	logic signed [BLW-1:0]          bl_s3, bl_s4;
	logic signed [COEFF_W+H:0]      cll_s3;
	logic signed [COEFF_W+L3W-H:0]  clh_s3;
	logic signed [CLW-1:0]          cl_s4;
	logic signed [DDW-1:0]          d_s5;

	assign sq_c   = (2*LW)'(ln_l) * (2*LW)'(ln_l);
	assign cube_c = (L2W+LW)'(l2_s1) * (L2W+LW)'(l_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= ln_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1  <= ln_tag;
			l_s1   <= ln_l;
			l2_s1  <= sq_c[2*LW-1:16];
			it_s2  <= it_s1;
			l_s2   <= l_s1;
			l3_s2  <= cube_c[L2W+LW-1:16];
			it_s3  <= it_s2;
			bl_s3  <= BLW'(coeff_b_q) * $signed({1'b0, l_s2});
			cll_s3 <= (COEFF_W+H+1)'(coeff_c_q) * $signed({1'b0, l3_s2[H-1:0]});
			clh_s3 <= (COEFF_W+L3W-H+1)'(coeff_c_q) * $signed({1'b0, l3_s2[L3W-1:H]});
			it_s4  <= it_s3;
			bl_s4  <= bl_s3;
			cl_s4  <= (CLW'(clh_s3) <<< H) + CLW'(cll_s3);
			it_s5  <= it_s4;
			d_s5   <= DDW'(coeff_a_q) + DDW'(bl_s4 >>> 16) + DDW'(cl_s4 >>> 16);
		end
	end

	// Shared division: reciprocal for Steinhart-Hart, rounded quotient
	// for the table.
	typedef struct packed {
		logic ok;
		logic tbl;
		logic sat_max;
		logic neg;
	} qtag_t;

	qtag_t            qt_c, qd_tag;
	logic [QNW-1:0]   qdvd_c, qd_quo;
	logic [QDW-1:0]   qdvs_c, qd_rem;
	logic [NUM_W-1:0] tmag_c;
	logic             d_pos_c, qd_vld;

	assign d_pos_c = !d_s5[DDW-1] && (d_s5 != '0);
	assign tmag_c  = it_s5.tnum[NUM_W-1] ? NUM_W'(-it_s5.tnum) : NUM_W'(it_s5.tnum);

	always_comb begin
		qt_c.ok      = it_s5.ok;
		qt_c.tbl     = it_s5.tbl;
		qt_c.sat_max = it_s5.sat_max || (!it_s5.tbl && !d_pos_c);
		qt_c.neg     = it_s5.tnum[NUM_W-1];
		if (it_s5.tbl) begin
			qdvd_c = QNW'(tmag_c);
			qdvs_c = QDW'(it_s5.tden);
		end else begin
			qdvd_c = SH_NUMER;
			qdvs_c = d_s5[QDW-1:0];
		end
	end

	ntc_div #(.NW(QNW), .DW(QDW), .TW($bits(qtag_t))) u_qdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s5),
		.tag_i  (qt_c),
		.dvd_i  (qdvd_c),
		.dvs_i  (qdvs_c),
		.vld_o  (qd_vld),
		.tag_o  (qd_tag),
		.quo_o  (qd_quo),
		.rem_o  (qd_rem)
	);

	// Floor correction and range checks.
	logic signed [QNW:0]     qx_c, tq_c, x_c, u_c;
	logic signed [TEMP_W-1:0] tsat_c;

	always_comb begin
		qx_c = $signed({1'b0, qd_quo});
		if (qd_tag.neg) begin
			tq_c = (qd_rem != '0) ? ~qx_c : -qx_c;
		end else begin
			tq_c = qx_c;
		end
		if (tq_c > (QNW+1)'(TEMP_MAX)) begin
			tsat_c = TEMP_MAX;
		end else if (tq_c < (QNW+1)'(TEMP_MIN)) begin
			tsat_c = TEMP_MIN;
		end else begin
			tsat_c = tq_c[TEMP_W-1:0];
		end
		x_c = qx_c - KELVIN_X10_M5;
		u_c = x_c + SH_HALF_SPAN;
	end

	logic      vld_s6, vld_s7, vld_s8;
	qtag_t     qt_s6, qt_s7, qt_s8;
	logic      hi_s6, lo_s6, hi_s7, lo_s7, hi_s8, lo_s8;
	logic [20:0] u_s6;
	logic [52:0] p_s7;
	logic signed [TEMP_W-1:0] tsat_s6, tsat_s7, tsat_s8, sh_s8;
	logic [16:0] b_c;

	assign b_c = p_s7[51:35];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= qd_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// Divide by ten through a reciprocal multiply, then pick the result.
	always_ff @(posedge clk) begin
		if (adv) begin
			qt_s6   <= qd_tag;
			tsat_s6 <= tsat_c;
			hi_s6   <= x_c >= SH_HALF_SPAN;
			lo_s6   <= x_c < -SH_HALF_SPAN;
			u_s6    <= u_c[20:0];
			qt_s7   <= qt_s6;
			tsat_s7 <= tsat_s6;
			hi_s7   <= hi_s6;
			lo_s7   <= lo_s6;
			p_s7    <= 53'(u_s6) * 53'(RECIP10);
			qt_s8   <= qt_s7;
			tsat_s8 <= tsat_s7;
			hi_s8   <= hi_s7;
			lo_s8   <= lo_s7;
			sh_s8   <= $signed(b_c - 17'd65536);
		end
	end

	// Output register.
	logic signed [TEMP_W-1:0] tfin_c;

	always_comb begin
		if (!qt_s8.ok) begin
			tfin_c = '0;
		end else if (qt_s8.tbl) begin
			tfin_c = tsat_s8;
		end else if (qt_s8.sat_max || hi_s8) begin
			tfin_c = TEMP_MAX;
		end else if (lo_s8) begin
			tfin_c = TEMP_MIN;
		end else begin
			tfin_c = sh_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {7'b0, tfin_c};
			m_tuser <= {qt_s8.ok && qt_s8.tbl, qt_s8.ok};
		end
	end

endmodule

`default_nettype wire

[rtl/core/ntc_div.sv]
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side tag that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [TW-1:0] tag_i,
	input  logic [NW-1:0] dvd_i,
	input  logic [DW-1:0] dvs_i,
	output logic          vld_o,
	output logic [TW-1:0] tag_o,
	output logic [NW-1:0] quo_o,
	output logic [DW-1:0] rem_o
);

	logic          vld_s [NW];
	logic [NW-1:0] dvd_s [NW];
	logic [DW-1:0] rem_s [NW];
	logic [DW-1:0] dvs_s [NW];
	logic [TW-1:0] tag_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          pv;
		logic [NW-1:0] pdvd;
		logic [DW-1:0] prem;
		logic [DW-1:0] pdvs;
		logic [TW-1:0] ptag;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign pv   = vld_i;
			assign pdvd = dvd_i;
			assign prem = '0;
			assign pdvs = dvs_i;
			assign ptag = tag_i;
		end else begin : g_next
			assign pv   = vld_s[k-1];
			assign pdvd = dvd_s[k-1];
			assign prem = rem_s[k-1];
			assign pdvs = dvs_s[k-1];
			assign ptag = tag_s[k-1];
		end

		// Shift in the next dividend bit and subtract where it fits.
		assign trial = {prem, pdvd[NW-1]};
		assign ge    = trial >= {1'b0, pdvs};
		assign diff  = trial - {1'b0, pdvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dvd_s[k] <= {pdvd[NW-2:0], ge};
				dvs_s[k] <= pdvs;
				tag_s[k] <= ptag;
			end
		end
	end

	assign vld_o = vld_s[NW-1];
	assign tag_o = tag_s[NW-1];
	assign quo_o = dvd_s[NW-1];
	assign rem_o = rem_s[NW-1];

endmodule

`default_nettype wire

[rtl/core/ntc_tbl.sv]
// ----------------------------------------------------------------------------
// ntc_tbl
// Forms the thermistor resistance, finds its table segment and prepares the
// numerator and denominator of the interpolation in four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_tbl import ntc_pkg::*; #(
	parameter int RW     = 35,
	parameter int POINTS = TABLE_POINTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  logic            ok_i,
	input  logic [RW-1:0]   rq_i,
	input  logic [PD_W-1:0] pd,
	output logic            vld_o,
	output ntc_item_t       item_o,
	output logic [RW-1:0]   r_o
);

	// Stage 1: resistance and segment search.
	logic signed [RW:0] r_c;
	logic               found_c;
	logic [SEG_W-1:0]   seg_c;

	assign r_c = $signed({1'b0, rq_i}) - $signed({{(RW+1-PD_W){1'b0}}, pd});

	always_comb begin
		found_c = 1'b0;
		seg_c   = '0;
		for (int i = 0; i < TABLE_CAP - 1; i++) begin
			if (i + 1 < POINTS && !found_c && r_c < TBL_RES[i+1]) begin
				found_c = 1'b1;
				seg_c   = SEG_W'(i);
			end
		end
	end

	logic               vld_s1, ok_s1, found_s1;
	logic signed [RW:0] r_s1;
	logic [SEG_W-1:0]   seg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1    <= ok_i;
			found_s1 <= found_c;
			r_s1     <= r_c;
			seg_s1   <= seg_c;
		end
	end

	// Stage 2: segment constants and offset into the segment.
	logic signed [31:0] ri_c;
	logic signed [23:0] d_c;
	logic               vld_s2, ok_s2, tbl_s2, sat_s2, slack_s2;
	logic signed [23:0] d_s2;
	logic signed [DT_W-1:0]  dt_s2;
	logic signed [DR_W-1:0]  dr_s2;
	logic signed [TDR_W-1:0] tdr_s2;
	logic signed [TI_W-1:0]  ti_s2;
	logic [RW-1:0]      r_s2;

	assign ri_c = TBL_RES[seg_s1];
	assign d_c  = $signed(r_s1[23:0]) - 24'(ri_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2    <= ok_s1;
			tbl_s2   <= found_s1;
			sat_s2   <= !found_s1 && (r_s1 < $signed((RW+1)'(1)));
			slack_s2 <= TBL_DR[seg_s1] <= 32'sd0;
			d_s2     <= d_c;
			dt_s2    <= DT_W'(TBL_DT[seg_s1]);
			dr_s2    <= DR_W'(TBL_DR[seg_s1]);
			tdr_s2   <= TBL_TDR[seg_s1];
			ti_s2    <= TI_W'(TBL_TEMP[seg_s1]);
			r_s2     <= (r_s1 >= $signed((RW+1)'(1))) ? r_s1[RW-1:0] : '0;
		end
	end

	// Stage 3: offset times temperature step.
	logic               vld_s3, ok_s3, tbl_s3, sat_s3, slack_s3;
	logic signed [39:0] prod_s3;
	logic signed [DR_W-1:0]  dr_s3;
	logic signed [TDR_W-1:0] tdr_s3;
	logic signed [TI_W-1:0]  ti_s3;
	logic [RW-1:0]      r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3    <= ok_s2;
			tbl_s3   <= tbl_s2;
			sat_s3   <= sat_s2;
			slack_s3 <= slack_s2;
			prod_s3  <= 40'(d_s2) * 40'(dt_s2);
			dr_s3    <= dr_s2;
			tdr_s3   <= tdr_s2;
			ti_s3    <= ti_s2;
			r_s3     <= r_s2;
		end
	end

	// Stage 4: rounded-division operands; a flat segment returns its start.
	logic signed [NUM_W-1:0] n_c, num_c;
	logic [DEN_W-1:0]        den_c;

	always_comb begin
		n_c = NUM_W'(tdr_s3) - NUM_W'(prod_s3);
		if (slack_s3) begin
			num_c = (NUM_W'(ti_s3) <<< 9) + NUM_W'(100);
			den_c = DEN_W'(200);
		end else begin
			num_c = (n_c <<< 9) + NUM_W'(dr_s3) * NUM_W'(100);
			den_c = DEN_W'(dr_s3) * DEN_W'(200);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_o.ok      <= ok_s3;
			item_o.tbl     <= tbl_s3;
			item_o.sat_max <= sat_s3;
			item_o.tnum    <= num_c;
			item_o.tden    <= den_c;
			r_o            <= r_s3;
		end
	end

endmodule

`default_nettype wire

[rtl/core/ntc_ln.sv]
// ----------------------------------------------------------------------------
// ntc_ln
// Pipelined natural logarithm in Q16: leading-one detect, normalize, 24
// squaring stages for the binary fraction, then scaling by ln 2.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_ln import ntc_pkg::*; #(
	parameter int RW = 35,
	parameter int TW = 1,
	parameter int EW = $clog2(RW),
	parameter int LW = EW + 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [TW-1:0] tag_i,
	input  logic [RW-1:0] r_i,
	output logic          vld_o,
	output logic [TW-1:0] tag_o,
	output logic [LW-1:0] l_o
);

	localparam int LGW  = EW + 24;
	localparam int SQN  = 24;
	localparam int PW   = LGW + 32;

	// Stage 1: position of the leading one.
	logic [EW-1:0] e_c;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < RW; i++) begin
			if (r_i[i]) begin
				e_c = EW'(i);
			end
		end
	end

	logic          vld_s1;
	logic [TW-1:0] tag_s1;
	logic [RW-1:0] r_s1;
	logic [EW-1:0] e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_i;
			r_s1   <= r_i;
			e_s1   <= e_c;
		end
	end

	// Stage 2: mantissa with its leading one at bit 30.
	logic [RW+29:0] norm_c;
	logic           vld_s2;
	logic [TW-1:0]  tag_s2;
	logic [30:0]    m_s2;
	logic [LGW-1:0] lg_s2;

	assign norm_c = {r_s1, 30'b0} >> e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			m_s2   <= norm_c[30:0];
			lg_s2  <= LGW'(e_s1) << 24;
		end
	end

	// Squaring stages: each squares the mantissa and yields one fraction bit.
	logic           sq_v   [SQN];
	logic [TW-1:0]  sq_tag [SQN];
	logic [30:0]    sq_m   [SQN];
	logic [LGW-1:0] sq_lg  [SQN];

	for (genvar j = 0; j < SQN; j++) begin : g_sq
		logic           pv;
		logic [TW-1:0]  ptag;
		logic [30:0]    pm;
		logic [LGW-1:0] plg;
		logic [61:0]    sq;
		logic [31:0]    t;

		if (j == 0) begin : g_first
			assign pv   = vld_s2;
			assign ptag = tag_s2;
			assign pm   = m_s2;
			assign plg  = lg_s2;
		end else begin : g_next
			assign pv   = sq_v[j-1];
			assign ptag = sq_tag[j-1];
			assign pm   = sq_m[j-1];
			assign plg  = sq_lg[j-1];
		end

		assign sq = 62'(pm) * 62'(pm);
		assign t  = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j] <= 1'b0;
			end else if (en) begin
				sq_v[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_tag[j] <= ptag;
				sq_m[j]   <= t[31] ? t[31:1] : t[30:0];
				sq_lg[j]  <= t[31] ? (plg | (LGW'(1) << (SQN - 1 - j))) : plg;
			end
		end
	end

	// Scale the base-2 logarithm by ln 2, then round to Q16.
	logic          vld_s3;
	logic [TW-1:0] tag_s3;
	logic [PW-1:0] p_s3;
	logic [PW:0]   rnd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s3 <= sq_v[SQN-1];
			vld_o  <= vld_s3;
		end
	end

	assign rnd_c = (PW+1)'(p_s3) + ((PW+1)'(1) << 39);

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= sq_tag[SQN-1];
			p_s3   <= PW'(sq_lg[SQN-1]) * PW'(LN2_Q32);
			tag_o  <= tag_s3;
			l_o    <= rnd_c[PW:40];
		end
	end

endmodule

`default_nettype wire

[rtl/core/ntc_chk.sv]
// ----------------------------------------------------------------------------
// ntc_chk
// Port-level checks for the NTC temperature converter, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [15:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [23:0] m_tdata,
	input wire [1:0]  m_tuser
);

	// A result that is not taken stays unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("ntc_chk: stalled result changed");

	// A stalled output also stalls the input side.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("ntc_chk: input taken while output stalled");

	// An invalid sample carries zero temperature and no table flag.
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[16:0] == 17'd0 && !m_tuser[1])
		else $error("ntc_chk: invalid result carries data");

	// Padding above the temperature stays zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:17] == 7'd0)
		else $error("ntc_chk: padding bits set");

endmodule

bind ntc_adc_to_temperature_core ntc_chk u_ntc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NTC sample to temperature converter. A local
// predictor computes the resistance, the table interpolation and the
// Steinhart-Hart path for every accepted sample. Each output transfer is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import ntc_pkg::*;

	localparam int PIPE_DEPTH = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int SEG_COUNT = TABLE_POINTS_DEF;

	typedef struct {
		logic                     ok;
		logic signed [TEMP_W-1:0] temp;
		logic                     tbl;
	} reading_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [15:0]         s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [23:0]         m_tdata;
	logic [1:0]          m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index;
	logic [COEFF_W-1:0]  cfg_data;

	// Predictor copy of the registers.
	longint    sh_a;
	longint    sh_b;
	longint    sh_c;
	longint    pd_ohms;

	reading_t  pending_readings[$];
	int        error_count;
	bit        no_idle;
	bit        hold_req;

	ntc_adc_to_temperature_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Floor division for a positive divisor.
	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic longint clamp_temp(longint t);
		if (t > 65535) begin
			return 65535;
		end
		if (t < -65536) begin
			return -65536;
		end
		return t;
	endfunction

	// floor(coef * m / 2^16), split as the hardware-width product would be.
	function automatic longint scale_q16(longint coef, longint m);
		longint lo;
		longint hi;
		lo = coef & 64'hFFFF;
		hi = (coef - lo) / 65536;
		return hi * m + ((lo * m) >>> 16);
	endfunction

	// Natural log in Q16 by log2 through repeated squaring of a Q30 mantissa.
	function automatic longint ln_q16(longint unsigned r);
		int unsigned      e;
		longint unsigned  m;
		longint unsigned  lg;
		e = 0;
		while (e < 63 && (r >> (e + 1)) != 0) begin
			e++;
		end
		if (e <= 30) begin
			m = r << (30 - e);
		end else begin
			m = r >> (e - 30);
		end
		lg = longint'(e) << 24;
		for (int k = 23; k >= 0; k--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				lg = lg | (64'd1 << k);
			end
		end
		return longint'((lg * 64'd2977044472 + (64'd1 << 39)) >> 40);
	endfunction

	// Expected output for one sample under the current register values.
	function automatic reading_t predict_reading(logic [ADC_W-1:0] adc);
		reading_t  res;
		longint    r;
		longint    t;
		longint    dr;
		longint    dt;
		longint    n;
		longint    den;
		longint    l;
		longint    l2;
		longint    l3;
		longint    d;
		longint    q;
		int        seg;
		res.ok = 1'b0;
		res.temp = '0;
		res.tbl = 1'b0;
		if (adc == 0) begin
			return res;
		end
		r = longint'((64'd4095 * longint'(pd_ohms)) / longint'(adc)) - pd_ohms;
		seg = -1;
		for (int i = 0; i + 1 < SEG_COUNT; i++) begin
			if (seg < 0 && r < longint'(TBL_RES[i+1])) begin
				seg = i;
			end
		end
		if (seg >= 0) begin
			dr = TBL_RES[seg+1] - TBL_RES[seg];
			dt = TBL_TEMP[seg] - TBL_TEMP[seg+1];
			if (dr <= 0) begin
				t = clamp_temp(floor_div(longint'(TBL_TEMP[seg]) * 512 + 100, 200));
			end else begin
				n = 256 * (longint'(TBL_TEMP[seg]) * dr - (r - TBL_RES[seg]) * dt);
				den = 100 * dr;
				t = clamp_temp(floor_div(2 * n + den, 2 * den));
			end
		end else if (r >= 1) begin
			l = ln_q16(r);
			l2 = (l * l) >>> 16;
			l3 = (l2 * l) >>> 16;
			d = sh_a + scale_q16(sh_b, l) + scale_q16(sh_c, l3);
			if (d <= 0) begin
				t = 65535;
			end else begin
				q = (longint'(10) <<< 56) / d;
				t = clamp_temp(floor_div(q - 699264 + 5, 10));
			end
		end else begin
			t = 65535;
		end
		res.ok = 1'b1;
		res.temp = t[TEMP_W-1:0];
		res.tbl = (seg >= 0);
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Output side: compare every result transfer with the oldest prediction.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[TEMP_W-1:0], 0);
			end else begin
				want = pending_readings.pop_front();
				if (m_tuser[0] !== want.ok) begin
					report_mismatch("valid_res", m_tuser[0], want.ok);
				end
				if ($signed(m_tdata[TEMP_W-1:0]) !== want.temp) begin
					report_mismatch("temperature", $signed(m_tdata[TEMP_W-1:0]), want.temp);
				end
				if (m_tuser[1] !== want.tbl) begin
					report_mismatch("from_table", m_tuser[1], want.tbl);
				end
			end
		end
	end

	// Output ready: random bursts, an occasional long hold, none at the end.
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				for (int cnt = 0; cnt < HOLD_CYCLES; cnt++) begin
					@(posedge clk);
				end
				hold_req = 1'b0;
			end else if (no_idle) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Send one sample and record its prediction on the transfer.
	task automatic send_sample(logic [ADC_W-1:0] adc);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, adc};
		do begin
			@(posedge clk);
		end while (!s_tready);
		pending_readings.push_back(predict_reading(adc));
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stop sending until all results are back and the pipe is empty.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [COEFF_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_COEFF_A: sh_a = longint'($signed(value));
			CFG_COEFF_B: sh_b = longint'($signed(value));
			CFG_COEFF_C: sh_c = longint'($signed(value));
			CFG_PULLDOWN: pd_ohms = longint'(value[PD_W-1:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic write_all(logic [COEFF_W-1:0] a, logic [COEFF_W-1:0] b,
			logic [COEFF_W-1:0] c, logic [COEFF_W-1:0] pd);
		write_reg(CFG_COEFF_A, a);
		write_reg(CFG_COEFF_B, b);
		write_reg(CFG_COEFF_C, c);
		write_reg(CFG_PULLDOWN, pd);
	endtask

	function automatic logic [COEFF_W-1:0] rand_coeff();
		return COEFF_W'({$urandom, $urandom});
	endfunction

	// Sample picked partly near the table and Steinhart-Hart ranges, partly at the edges and partly at random.
	function automatic logic [ADC_W-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return ADC_W'($urandom_range(430, 790));
			1: return ADC_W'($urandom_range(1, 460));
			2: return $urandom_range(0, 3) == 0 ? 12'd0 : 12'd4095;
			default: return ADC_W'($urandom);
		endcase
	endfunction

	// Edge samples and the table boundaries under the reset registers.
	task automatic test_directed();
		logic [ADC_W-1:0] list [16] = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd2048, 12'd447,
			12'd448, 12'd500, 12'd600, 12'd768, 12'd769, 12'd1000, 12'd100, 12'd20,
			12'd2730, 12'd1365};
		foreach (list[i]) begin
			send_sample(list[i]);
		end
		wait_drained();
	endtask

	// Register extremes: zero and maximum pull-down, nonpositive denominator.
	task automatic test_register_extremes();
		write_all(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'd0);
		send_sample(12'd1);
		send_sample(12'd4095);
		send_sample(12'd2000);
		wait_drained();
		write_all(48'h8000_0000_0000, 48'h0, 48'h0, 48'd524287);
		send_sample(12'd1);
		send_sample(12'd4095);
		send_sample(12'd300);
		send_sample(12'd0);
		wait_drained();
		write_all(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'd1);
		send_sample(12'd1);
		send_sample(12'd4095);
		send_sample(12'd2);
		wait_drained();
		write_all(48'd1, 48'd1, 48'd1, 48'h7FFF_FFFF_FFFF);
		send_sample(12'd1);
		send_sample(12'd3000);
		wait_drained();
	endtask

	// Random samples over several register settings.
	task automatic test_random_settings();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0) begin
				write_all(COEFF_A_RST, COEFF_B_RST, COEFF_C_RST, COEFF_W'(PD_RST));
			end else if (phase % 2 == 1) begin
				write_all(rand_coeff(), rand_coeff(), rand_coeff(),
					COEFF_W'($urandom_range(0, 524287)));
			end else begin
				write_all(COEFF_W'($urandom_range(0, 1 << 30)) * 48'd512,
					COEFF_W'($urandom_range(0, 1 << 30)) * 48'd64,
					COEFF_W'($urandom_range(0, 1 << 26)),
					COEFF_W'($urandom_range(1000, 100000)));
			end
			repeat (80) begin
				send_sample(rand_sample());
			end
			wait_drained();
		end
	endtask

	// Long hold on the output while samples keep coming.
	task automatic test_backpressure();
		write_all(COEFF_A_RST, COEFF_B_RST, COEFF_C_RST, COEFF_W'(PD_RST));
		hold_req = 1'b1;
		repeat (200) begin
			send_sample(rand_sample());
		end
		wait_drained();
	endtask

	// Closing stretch with no idling on either side.
	task automatic test_full_rate();
		no_idle = 1'b1;
		repeat (120) begin
			send_sample(rand_sample());
		end
		s_tvalid <= 1'b0;
	endtask

	// Run limit.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		error_count = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		sh_a = COEFF_A_RST;
		sh_b = COEFF_B_RST;
		sh_c = COEFF_C_RST;
		pd_ohms = PD_RST;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_COEFF_A;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		test_full_rate();
		wait (pending_readings.size() == 0);
		repeat (PIPE_DEPTH) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
